@@ hw/rtl/gnc_pkg.sv @@
package gnc_pkg;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;
    localparam logic KIND_NORM = 1'b0;
    localparam logic KIND_ELEM = 1'b1;
    localparam logic [31:0] SCALE_ONE = 32'h8000_0000;
    localparam logic [31:0] CLIP_LIMIT_RESET = 32'd65536;
    // element RAM depth; the 12-bit index port addresses all of it
    localparam int MAX_ELEMENTS = 4096;
endpackage

@@ hw/rtl/gnc_ram.sv @@
module gnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/gnc_sqrt.sv @@
// Bit-pair restoring square root, one result bit per cycle.
module gnc_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] n_rem;
    logic [33:0] trial;

    always_comb begin
        n_rem = {r_rem[31:0], r_val[63:62]};
        trial = n_rem - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (!trial[33]) begin
                    r_rem  <= trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
endmodule

@@ hw/rtl/gnc_div.sv @@
// Restoring divider: floor(num63 / den33).
module gnc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [62:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] shifted;
    logic [34:0] diff;

    always_comb begin
        shifted = {r_rem[32:0], r_q[62]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!diff[34]) begin
                    r_rem <= diff[33:0];
                    r_q   <= {r_q[61:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q   <= {r_q[61:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd62) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q[31:0];
endmodule

@@ hw/rtl/global_norm_gradient_clipper_unit.sv @@
// Global L2-norm gradient clipper. A load stores one Q16.16 element in the
// element RAM and adds its square to a saturating 64-bit sum in an accumulate
// state. A load marked last then runs a square root and, when the norm
// exceeds the clip limit, a divide for the Q1.31 scale, then emits the norm
// report. A fetch steps through a registered RAM read, a 32x32 multiply, and
// the result register. One item is in flight at a time; the output register
// frees the input side once a result is taken. The clip limit is written
// through its own valid/ready channel; the user is to write it only while the
// block is idle, which the block itself does not enforce.
module global_norm_gradient_clipper_unit
    import gnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_grad_value,
    input  logic        i_last,
    input  logic [11:0] i_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [31:0] o_norm,
    output logic        o_clipped,
    output logic        o_overflow_error,
    output logic [31:0] o_scaled_value,
    output logic        o_index_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]    r_state;
    logic [31:0]   r_clip_limit;
    logic [CW-1:0] r_count;
    logic [63:0]   r_sum;
    logic          r_sat;
    logic [31:0]   r_scale;
    logic          r_complete;
    logic [31:0]   r_norm;
    logic          r_clipped;
    logic          r_last;
    logic [63:0]   r_sq;
    logic          r_neg;
    logic          r_ierr;
    logic [63:0]   r_prod;

    logic          ram_we;
    logic [31:0]   ram_rdata;
    logic          sqrt_start, sqrt_done, div_start, div_done;
    logic [31:0]   sqrt_root, div_quot;
    logic [31:0]   in_mag, rd_mag, res;
    logic [64:0]   sum_ext;
    logic          accept;
    logic          idx_ok;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign o_cfg_ready = 1'b1;

    assign in_mag = i_grad_value[31] ? (~i_grad_value + 32'd1) : i_grad_value;
    assign rd_mag = ram_rdata[31] ? (~ram_rdata + 32'd1) : ram_rdata;
    assign sum_ext = {1'b0, r_sum} + {1'b0, r_sq};
    assign idx_ok = ({1'b0, i_index} < r_count);

    // The write happens on accept; a full memory drops the element.
    assign ram_we = accept && (i_command == CMD_LOAD)
                    && ((r_complete ? '0 : r_count) < CW'(MAX_ELEMENTS));

    gnc_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_complete ? AW'(0) : r_count[AW-1:0]),
        .i_wdata(i_grad_value),
        .i_raddr(i_index[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign sqrt_start = (r_state == S_LOAD) && r_last;
    gnc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_value(sum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_ext[63:0]),
        .o_done(sqrt_done), .o_root(sqrt_root)
    );

    assign div_start = (r_state == S_SQRT) && sqrt_done && (sqrt_root > r_clip_limit);
    gnc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({r_clip_limit, 31'd0}), .i_den({1'b0, sqrt_root} + 33'd1),
        .o_done(div_done), .o_quot(div_quot)
    );

    assign res = r_prod[62:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clip_limit <= CLIP_LIMIT_RESET;
            r_count      <= '0;
            r_sum        <= '0;
            r_sat        <= 1'b0;
            r_scale      <= SCALE_ONE;
            r_complete   <= 1'b0;
            r_norm       <= '0;
            r_clipped    <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clip_limit <= i_cfg_data;
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last  <= i_last;
                        if (i_command == CMD_LOAD) begin
                            r_sq <= ram_we ? 64'(in_mag) * 64'(in_mag) : '0;
                            if (r_complete) begin
                                r_count    <= ram_we ? CW'(1) : '0;
                                r_sum      <= '0;
                                r_sat      <= 1'b0;
                                r_scale    <= SCALE_ONE;
                                r_clipped  <= 1'b0;
                                r_complete <= 1'b0;
                            end else if (ram_we) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_state <= S_LOAD;
                        end else begin
                            r_ierr  <= !idx_ok;
                            r_state <= S_RD;
                        end
                    end
                end
                S_LOAD: begin
                    if (sum_ext[64]) begin
                        r_sum <= 64'hFFFF_FFFF_FFFF_FFFF;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= sum_ext[63:0];
                    end
                    r_state <= r_last ? S_SQRT : S_IDLE;
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_norm <= sqrt_root;
                        r_complete <= 1'b1;
                        if (sqrt_root > r_clip_limit) begin
                            r_clipped <= 1'b1;
                            r_state   <= S_DIV;
                        end else begin
                            r_clipped <= 1'b0;
                            r_scale   <= SCALE_ONE;
                            o_kind <= KIND_NORM;
                            o_norm <= sqrt_root;
                            o_clipped <= 1'b0;
                            o_overflow_error <= r_sat;
                            o_scaled_value <= '0;
                            o_index_error <= 1'b0;
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_scale <= div_quot;
                        o_kind <= KIND_NORM;
                        o_norm <= r_norm;
                        o_clipped <= 1'b1;
                        o_overflow_error <= r_sat;
                        o_scaled_value <= '0;
                        o_index_error <= 1'b0;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_neg   <= ram_rdata[31];
                    r_prod  <= 64'(rd_mag) * 64'(r_scale);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_kind <= KIND_ELEM;
                    o_norm <= r_norm;
                    o_clipped <= r_clipped;
                    o_overflow_error <= r_sat;
                    o_index_error <= r_ierr;
                    o_scaled_value <= r_ierr ? 32'd0 : (r_neg ? (~res + 32'd1) : res);
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
